[sv/lss_pkg.sv]
// lss_pkg: shared constants and types for the laplacian sharpening unit
// no dependencies; imported by lss_cell and laplacian_sharpen_3x3_unit

package lss_pkg;

    // pixel and configuration field widths
    localparam int PIX_BITS     = 8;
    localparam int PIX_MAX      = 255;
    localparam int CFG_W_BITS   = 12;
    localparam int CFG_H_BITS   = 13;
    localparam int CFG_IDX_BITS = 3;

    // defaults for the top level parameters
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_COEF_BITS  = 8;

    // register reset values
    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_LEFT   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_CENTRE = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_RIGHT  = 3'd4;

    // grey conversion weights, q14
    localparam int GREY_B      = 1868;
    localparam int GREY_G      = 9617;
    localparam int GREY_R      = 4899;
    localparam int GREY_ROUND  = 8192;
    localparam int GREY_SHIFT  = 14;
    localparam int GREY_SUM_W  = 22;

    // sharpening gain, 0.99 in q16
    localparam int SCALE_Q16  = 64881;
    localparam int SCALE_BITS = 16;

    typedef struct packed {
        logic load;   // shift a new column into the cell
        logic calc;   // register the cell's weighted column sum
    } t_cell_ctl;

    typedef struct packed {
        logic border;
        logic last;
    } t_ctl;

endpackage

[sv/lss_cell.sv]
// lss_cell: one column of the 3x3 grey window with its column of weights
// depends on lss_pkg; chained three deep in laplacian_sharpen_3x3_unit

module lss_cell #(
    parameter int COEF_BITS = lss_pkg::DEF_COEF_BITS
) (
    input  logic                                       i_clk,
    input  lss_pkg::t_cell_ctl                         i_ctl,
    input  logic [3*lss_pkg::PIX_BITS-1:0]             i_col,   // rows -1, 0, +1 from bit 0
    input  logic [3*COEF_BITS-1:0]                     i_coef,  // weights for rows -1, 0, +1
    output logic [3*lss_pkg::PIX_BITS-1:0]             o_col,
    output logic signed [COEF_BITS+lss_pkg::PIX_BITS+2:0] o_psum
);
    import lss_pkg::*;

    localparam int PROD_W = COEF_BITS + PIX_BITS + 1;
    localparam int PSUM_W = PROD_W + 2;

    logic [3*PIX_BITS-1:0]     r_col;
    logic signed [PSUM_W-1:0]  r_psum;
    logic signed [PROD_W-1:0]  prod [3];
    logic signed [PSUM_W-1:0]  n_psum;

    for (genvar k = 0; k < 3; k++) begin : g_tap
        assign prod[k] = $signed({1'b0, r_col[k*PIX_BITS +: PIX_BITS]})
                       * $signed(i_coef[k*COEF_BITS +: COEF_BITS]);
    end

    assign n_psum = $signed({{2{prod[0][PROD_W-1]}}, prod[0]})
                  + $signed({{2{prod[1][PROD_W-1]}}, prod[1]})
                  + $signed({{2{prod[2][PROD_W-1]}}, prod[2]});

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_col <= i_col;
        end
        if (i_ctl.calc) begin
            r_psum <= n_psum;
        end
    end

    assign o_col  = r_col;
    assign o_psum = r_psum;

endmodule

[sv/laplacian_sharpen_3x3_unit.sv]
// laplacian_sharpen_3x3_unit: streaming 3x3 sharpening of a bgr frame
// depends on lss_pkg and lss_cell
//
// Usage:
//   Pixels arrive on the slave stream in raster order, tdata = {red, green, blue}.
//   tuser high marks a drain request: no pixel, it only pushes out the frame tail.
//   Sharpened pixels leave on the master stream, tlast on the last pixel of a frame.
//   Pixel n leaves once pixel n+width+1 has been taken; after the last input pixel
//   width+1 drain requests flush the remainder of the frame.
//   A pixel request is taken every cycle when the output side keeps up and no
//   configuration write is settling; the pipeline is five registers deep (r1_v to
//   r4_v and r_out_v), and a result reaches the master side through all five.
//   Throughput is one pixel per cycle while nothing stalls: each cycle the grey ring
//   is read at two positions and written, and the colour ring read and written.
//   Any output stall (tready low with tvalid high) freezes the whole pipeline and
//   drops the slave tready in the same cycle; nothing is lost.
//   The configuration channel writes image_width (0), image_height (1) and the
//   left, centre and right kernel columns (2..4); a size write restarts the frame.
//   In the cycle after reset and after every configuration write the slave side
//   holds tready low while the frame size settles. The line rings are not cleared.

module laplacian_sharpen_3x3_unit #(
    parameter int MAX_WIDTH  = lss_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lss_pkg::DEF_MAX_HEIGHT,
    parameter int COEF_BITS  = lss_pkg::DEF_COEF_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [lss_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [((3*COEF_BITS > lss_pkg::CFG_H_BITS) ?
                   3*COEF_BITS : lss_pkg::CFG_H_BITS)-1:0] i_cfg_data,
    // pixel input
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [23:0]                       i_s_axis_tdata,   // in_blue, in_green, in_red
    input  logic                              i_s_axis_tuser,   // drain
    // pixel output
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [23:0]                       o_m_axis_tdata,   // out_blue, out_green, out_red
    output logic                              o_m_axis_tlast    // frame_end
);
    import lss_pkg::*;

    localparam int KW     = 3 * COEF_BITS;
    localparam int CW     = $clog2(MAX_WIDTH + 1);
    localparam int RH     = $clog2(MAX_HEIGHT + 1);
    localparam int PW     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int GD     = 2 * MAX_WIDTH;
    localparam int GA     = $clog2(GD);
    localparam int CD     = MAX_WIDTH + 2;
    localparam int CA     = $clog2(CD);
    localparam int PSUM_W = COEF_BITS + PIX_BITS + 3;
    localparam int SUM_W  = PSUM_W + 2;
    localparam int PROD_W = SUM_W + SCALE_BITS + 1;
    localparam int VW     = PROD_W + 1;
    localparam int QW     = VW - SCALE_BITS;
    localparam int CPIX   = 3 * PIX_BITS;

    // configuration
    logic                   cfg_take;
    logic                   size_write;
    logic [CFG_W_BITS-1:0]  r_cfg_w;
    logic [CFG_H_BITS-1:0]  r_cfg_h;
    logic [KW-1:0]          r_kern [3];
    logic                   r_busy;
    logic [CW-1:0]          n_w, r_w;
    logic [RH-1:0]          n_h, r_h;
    logic [PW-1:0]          n_total, r_total;

    // frame position
    logic [PW-1:0]          r_recv, r_opos;
    logic [CW-1:0]          r_ocol;
    logic [RH-1:0]          r_orow;
    logic [GA-1:0]          r_gwp;
    logic [CA-1:0]          r_cwp, r_cop;

    // request decode
    logic                   en, take, pix, emit, interior, last;
    logic [PW-1:0]          recv_n, pend;
    logic [GREY_SUM_W-1:0]  gsum;
    logic [PIX_BITS-1:0]    grey;
    logic [GA:0]            two_w, lag1, lag2;

    // line rings
    logic [PIX_BITS-1:0]    r_grey_mem [GD];
    logic [CPIX-1:0]        r_col_mem  [CD];

    // pipeline
    logic                   r1_v, r2_v, r3_v, r4_v, r_out_v, r1_shift;
    t_ctl                   r1_ctl, r2_ctl, r3_ctl, r4_ctl;
    logic [CPIX-1:0]        r1_colour, r2_colour, r3_colour, r4_colour;
    logic [PIX_BITS-1:0]    r1_grey, r1_ga, r1_gb;
    logic signed [PROD_W-1:0] r4_prod;
    logic [CPIX-1:0]        r_out_data;
    logic                   r_out_last;

    // window cells
    t_cell_ctl              cell_ctl;
    logic [CPIX-1:0]        col_chain [3];
    logic signed [PSUM_W-1:0] cell_psum [3];
    logic signed [SUM_W-1:0]  sum3;
    logic signed [PROD_W-1:0] n_prod;
    logic [CPIX-1:0]        sharp;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;
    assign cfg_take    = i_cfg_valid & o_cfg_ready;
    assign size_write  = cfg_take & ((i_cfg_index == REG_IMAGE_WIDTH) ||
                                     (i_cfg_index == REG_IMAGE_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_W_BITS'(RESET_WIDTH);
            r_cfg_h <= CFG_H_BITS'(RESET_HEIGHT);
            r_kern  <= '{default: '0};
            r_busy  <= 1'b1;
        end else begin
            r_busy <= cfg_take;
            if (cfg_take) begin
                unique case (i_cfg_index)
                    REG_IMAGE_WIDTH:   r_cfg_w   <= i_cfg_data[CFG_W_BITS-1:0];
                    REG_IMAGE_HEIGHT:  r_cfg_h   <= i_cfg_data[CFG_H_BITS-1:0];
                    REG_KERNEL_LEFT:   r_kern[0] <= i_cfg_data[KW-1:0];
                    REG_KERNEL_CENTRE: r_kern[1] <= i_cfg_data[KW-1:0];
                    REG_KERNEL_RIGHT:  r_kern[2] <= i_cfg_data[KW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // saturate sizes to 1..max
    always_comb begin
        n_w = (r_cfg_w == '0) ? CW'(1) :
              ((int'(r_cfg_w) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(r_cfg_w));
        n_h = (r_cfg_h == '0) ? RH'(1) :
              ((int'(r_cfg_h) > MAX_HEIGHT) ? RH'(MAX_HEIGHT) : RH'(r_cfg_h));
        n_total = PW'(n_w) * PW'(n_h);
    end

    always_ff @(posedge i_clk) begin
        r_w     <= n_w;
        r_h     <= n_h;
        r_total <= n_total;
    end

    // ---------------- request decode ----------------
    assign en              = ~r_out_v | i_m_axis_tready;
    assign o_s_axis_tready = en & ~r_busy;
    assign take            = i_s_axis_tvalid & o_s_axis_tready;
    assign pix             = take & ~i_s_axis_tuser & (r_recv < r_total);

    always_comb begin
        recv_n   = r_recv + PW'(pix);
        pend     = recv_n - r_opos;
        // normal release once width+2 pixels are pending, else frame tail on a request with no pixel
        emit     = take & ((pend >= PW'(r_w) + PW'(2)) |
                           (~pix & (recv_n == r_total) & (r_opos < recv_n)));
        interior = (r_orow != '0) && ((r_orow + RH'(1)) < r_h) &&
                   (r_ocol != '0) && ((r_ocol + CW'(1)) < r_w);
        last     = (r_opos + PW'(1)) == r_total;

        gsum = GREY_SUM_W'(GREY_B) * GREY_SUM_W'(i_s_axis_tdata[7:0])
             + GREY_SUM_W'(GREY_G) * GREY_SUM_W'(i_s_axis_tdata[15:8])
             + GREY_SUM_W'(GREY_R) * GREY_SUM_W'(i_s_axis_tdata[23:16])
             + GREY_SUM_W'(GREY_ROUND);
        grey = gsum[GREY_SHIFT +: PIX_BITS];

        // ring positions one and two rows back
        two_w = (GA+1)'(r_w) + (GA+1)'(r_w);
        lag1  = ({1'b0, r_gwp} >= (GA+1)'(r_w)) ? {1'b0, r_gwp} - (GA+1)'(r_w)
                                                : {1'b0, r_gwp} + (GA+1)'(GD) - (GA+1)'(r_w);
        lag2  = ({1'b0, r_gwp} >= two_w) ? {1'b0, r_gwp} - two_w
                                         : {1'b0, r_gwp} + (GA+1)'(GD) - two_w;
    end

    // ---------------- frame counters ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recv <= '0;
            r_opos <= '0;
            r_ocol <= '0;
            r_orow <= '0;
            r_cwp  <= '0;
            r_cop  <= '0;
            r_gwp  <= '0;
        end else if (size_write) begin
            r_recv <= '0;
            r_opos <= '0;
            r_ocol <= '0;
            r_orow <= '0;
            r_cwp  <= '0;
            r_cop  <= '0;
        end else if (take) begin
            if (pix) begin
                r_recv <= recv_n;
                r_cwp  <= (r_cwp == CA'(CD - 1)) ? '0 : r_cwp + CA'(1);
                r_gwp  <= (r_gwp == GA'(GD - 1)) ? '0 : r_gwp + GA'(1);
            end
            if (emit) begin
                if (last) begin
                    r_recv <= '0;
                    r_opos <= '0;
                    r_ocol <= '0;
                    r_orow <= '0;
                    r_cwp  <= '0;
                    r_cop  <= '0;
                end else begin
                    r_opos <= r_opos + PW'(1);
                    r_cop  <= (r_cop == CA'(CD - 1)) ? '0 : r_cop + CA'(1);
                    if ((r_ocol + CW'(1)) == r_w) begin
                        r_ocol <= '0;
                        r_orow <= r_orow + RH'(1);
                    end else begin
                        r_ocol <= r_ocol + CW'(1);
                    end
                end
            end
        end
    end

    // ---------------- line rings ----------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ga <= r_grey_mem[lag1[GA-1:0]];
            r1_gb <= r_grey_mem[lag2[GA-1:0]];
            if (pix) begin
                r_grey_mem[r_gwp] <= grey;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_colour <= r_col_mem[r_cop];
            if (pix) begin
                r_col_mem[r_cwp] <= i_s_axis_tdata;
            end
        end
    end

    // ---------------- window cells ----------------
    // cell 0 holds the newest column (offset +1), cell 2 the oldest (offset -1)
    assign cell_ctl     = '{load: en & r1_shift, calc: en};
    assign col_chain[0] = {r1_grey, r1_ga, r1_gb};

    for (genvar k = 0; k < 3; k++) begin : g_cell
        if (k < 2) begin : g_mid
            lss_cell #(.COEF_BITS(COEF_BITS)) u_cell (
                .i_clk  (i_clk),
                .i_ctl  (cell_ctl),
                .i_col  (col_chain[k]),
                .i_coef (r_kern[2-k]),
                .o_col  (col_chain[k+1]),
                .o_psum (cell_psum[k])
            );
        end else begin : g_end
            lss_cell #(.COEF_BITS(COEF_BITS)) u_cell (
                .i_clk  (i_clk),
                .i_ctl  (cell_ctl),
                .i_col  (col_chain[k]),
                .i_coef (r_kern[2-k]),
                .o_col  (),
                .o_psum (cell_psum[k])
            );
        end
    end

    assign sum3 = $signed({{2{cell_psum[0][PSUM_W-1]}}, cell_psum[0]})
                + $signed({{2{cell_psum[1][PSUM_W-1]}}, cell_psum[1]})
                + $signed({{2{cell_psum[2][PSUM_W-1]}}, cell_psum[2]});
    assign n_prod = sum3 * $signed({1'b0, SCALE_BITS'(SCALE_Q16)});

    // ---------------- add, round half to even, clamp ----------------
    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic [PIX_BITS-1:0]   chv;
        logic signed [VW-1:0]  v;
        logic [QW-1:0]         q, qr;
        logic [SCALE_BITS-1:0] rem;
        logic                  inc, positive;

        assign chv      = r4_colour[c*PIX_BITS +: PIX_BITS];
        assign v        = $signed({{(VW-PIX_BITS-SCALE_BITS){1'b0}}, chv,
                                   {SCALE_BITS{1'b0}}})
                        + $signed({r4_prod[PROD_W-1], r4_prod});
        assign q        = v[VW-1:SCALE_BITS];
        assign rem      = v[SCALE_BITS-1:0];
        assign inc      = (rem > (SCALE_BITS'(1) << (SCALE_BITS-1))) ||
                          ((rem == (SCALE_BITS'(1) << (SCALE_BITS-1))) && q[0]);
        assign qr       = q + QW'(inc);
        assign positive = ~v[VW-1] & (v != '0);

        always_comb begin
            if (r4_ctl.border) begin
                sharp[c*PIX_BITS +: PIX_BITS] = chv;
            end else if (!positive) begin
                sharp[c*PIX_BITS +: PIX_BITS] = '0;
            end else if (qr > QW'(PIX_MAX)) begin
                sharp[c*PIX_BITS +: PIX_BITS] = PIX_BITS'(PIX_MAX);
            end else begin
                sharp[c*PIX_BITS +: PIX_BITS] = qr[PIX_BITS-1:0];
            end
        end
    end

    // ---------------- pipeline registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v     <= 1'b0;
            r1_shift <= 1'b0;
            r2_v     <= 1'b0;
            r3_v     <= 1'b0;
            r4_v     <= 1'b0;
            r_out_v  <= 1'b0;
        end else if (en) begin
            r1_v     <= emit;
            r1_shift <= pix;
            r2_v     <= r1_v;
            r3_v     <= r2_v;
            r4_v     <= r3_v;
            r_out_v  <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_ctl     <= '{border: ~interior, last: last};
            r1_grey    <= grey;
            r2_ctl     <= r1_ctl;
            r2_colour  <= r1_colour;
            r3_ctl     <= r2_ctl;
            r3_colour  <= r2_colour;
            r4_ctl     <= r3_ctl;
            r4_colour  <= r3_colour;
            r4_prod    <= n_prod;
            r_out_data <= sharp;
            r_out_last <= r4_ctl.last;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    a_out_behind_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_opos <= r_recv)
        else $error("output position ran ahead of input");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> ((r_recv - r_opos) <= (PW'(r_w) + PW'(1))))
        else $error("more than width+1 pixels pending");

    a_out_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_ocol < r_w))
        else $error("output column outside the row");
`endif

endmodule

[tb/laplacian_sharpen_3x3_checker.sv]
`timescale 1ns / 100ps
// laplacian_sharpen_3x3_checker: watches the configuration, pixel and result streams of the
// sharpening unit, predicts every sharpened pixel and compares it with what leaves the unit
// depends on lss_pkg

module laplacian_sharpen_3x3_checker #(
    parameter int MAX_WIDTH  = lss_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lss_pkg::DEF_MAX_HEIGHT,
    parameter int COEF_BITS  = lss_pkg::DEF_COEF_BITS,
    parameter int CFG_D_BITS = (3*COEF_BITS > lss_pkg::CFG_H_BITS) ?
                               3*COEF_BITS : lss_pkg::CFG_H_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [lss_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_D_BITS-1:0]            i_cfg_data,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [23:0]                      i_s_tdata,   // in_blue, in_green, in_red
    input  logic                             i_s_tuser,   // drain
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [23:0]                      i_m_tdata,   // out_blue, out_green, out_red
    input  logic                             i_m_tlast,   // frame_end
    output int                               o_errors,
    output int                               o_pending
);
    import lss_pkg::*;

    localparam int GREY_RING   = 2 * MAX_WIDTH + 4;
    localparam int COLOUR_RING = MAX_WIDTH + 2;
    localparam int LUMA_B      = 1868;
    localparam int LUMA_G      = 9617;
    localparam int LUMA_R      = 4899;
    localparam int LUMA_ROUND  = 8192;
    localparam int LUMA_SHIFT  = 14;
    localparam longint GAIN_Q16 = 64881;    // 0.99
    localparam int REPORT_CAP  = 40;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } bgr_t;

    typedef struct {
        bgr_t pix;
        logic last;
    } sharpened_t;

    logic [CFG_W_BITS-1:0]  width_q;
    logic [CFG_H_BITS-1:0]  height_q;
    logic [3*COEF_BITS-1:0] kern_col [3];
    logic [7:0]             grey_ring [GREY_RING];
    bgr_t                   colour_ring [COLOUR_RING];
    int unsigned            col_in, row_in, out_idx;
    sharpened_t             sharpened_q [$];
    int                     mismatches = 0;
    int                     reported = 0;

    function automatic int unsigned frame_w();
        if (width_q == 0) return 1;
        if (width_q > MAX_WIDTH) return MAX_WIDTH;
        return width_q;
    endfunction

    function automatic int unsigned frame_h();
        if (height_q == 0) return 1;
        if (height_q > MAX_HEIGHT) return MAX_HEIGHT;
        return height_q;
    endfunction

    function automatic longint weight(int col, int row);
        logic signed [COEF_BITS-1:0] c;
        c = kern_col[col][row*COEF_BITS +: COEF_BITS];
        return longint'(c);
    endfunction

    function automatic logic [7:0] grey_of(bgr_t px);
        int unsigned acc;
        acc = LUMA_B * px.blue + LUMA_G * px.green + LUMA_R * px.red + LUMA_ROUND;
        return 8'(acc >> LUMA_SHIFT);
    endfunction

    // add the scaled sum, round half to even, clamp to a byte
    function automatic logic [7:0] sharpen_chan(logic [7:0] ch, longint sum);
        int     chi;
        longint v, q, rem;
        chi = ch;
        v = longint'(chi) * 65536 + sum * GAIN_Q16;
        if (v <= 0) return 8'd0;
        q = v >>> 16;
        rem = v & 64'hFFFF;
        if (rem > 32768 || (rem == 32768 && q[0])) q++;
        if (q > 255) return 8'hFF;
        return q[7:0];
    endfunction

    task automatic restart_frame();
        col_in = 0;
        row_in = 0;
        out_idx = 0;
    endtask

    task automatic write_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_D_BITS-1:0] value);
        case (idx)
            REG_IMAGE_WIDTH: begin
                width_q = value[CFG_W_BITS-1:0];
                restart_frame();
            end
            REG_IMAGE_HEIGHT: begin
                height_q = value[CFG_H_BITS-1:0];
                restart_frame();
            end
            REG_KERNEL_LEFT:   kern_col[0] = value[3*COEF_BITS-1:0];
            REG_KERNEL_CENTRE: kern_col[1] = value[3*COEF_BITS-1:0];
            REG_KERNEL_RIGHT:  kern_col[2] = value[3*COEF_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic take_pixel_request(bgr_t px, logic drain);
        int unsigned w, h, total, recv, o, r, c, idx, i, j;
        logic        taken;
        longint      sum;
        sharpened_t  res;
        w = frame_w();
        h = frame_h();
        total = w * h;
        recv = row_in * w + col_in;
        taken = 1'b0;
        sum = 0;
        if (!drain && recv < total) begin
            grey_ring[recv % GREY_RING] = grey_of(px);
            colour_ring[recv % COLOUR_RING] = px;
            taken = 1'b1;
            col_in++;
            if (col_in >= w) begin
                col_in = 0;
                row_in++;
            end
            recv++;
        end
        o = out_idx;
        // a pixel leaves once its lower right neighbour is in, or while flushing the tail
        if (!((recv >= o && recv - o >= w + 2) || (!taken && recv == total && o < recv)))
            return;
        r = o / w;
        c = o % w;
        res.pix = colour_ring[o % COLOUR_RING];
        if (r > 0 && r + 1 < h && c > 0 && c + 1 < w) begin
            for (i = 0; i < 3; i++) begin
                for (j = 0; j < 3; j++) begin
                    idx = o + j * w + i - w - 1;
                    sum += longint'(grey_ring[idx % GREY_RING]) * weight(i, j);
                end
            end
            res.pix.blue  = sharpen_chan(res.pix.blue, sum);
            res.pix.green = sharpen_chan(res.pix.green, sum);
            res.pix.red   = sharpen_chan(res.pix.red, sum);
        end
        res.last = (o + 1 == total);
        if (res.last)
            restart_frame();
        else
            out_idx = o + 1;
        sharpened_q.push_back(res);
    endtask

    task automatic check_result();
        sharpened_t want;
        bgr_t       got;
        got = bgr_t'(i_m_tdata);
        if (sharpened_q.size() == 0) begin
            mismatches++;
            if (reported < REPORT_CAP) begin
                reported++;
                $display("%0t: result with nothing expected: b=%0d g=%0d r=%0d last=%0b",
                         $time, got.blue, got.green, got.red, i_m_tlast);
            end
            return;
        end
        want = sharpened_q.pop_front();
        if (got.blue !== want.pix.blue || got.green !== want.pix.green ||
            got.red !== want.pix.red || i_m_tlast !== want.last) begin
            mismatches++;
            if (reported < REPORT_CAP) begin
                reported++;
                $display("%0t: mismatch: expected b=%0d g=%0d r=%0d last=%0b, got b=%0d g=%0d r=%0d last=%0b",
                         $time, want.pix.blue, want.pix.green, want.pix.red, want.last,
                         got.blue, got.green, got.red, i_m_tlast);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_q = RESET_WIDTH;
            height_q = RESET_HEIGHT;
            kern_col[0] = '0;
            kern_col[1] = '0;
            kern_col[2] = '0;
            restart_frame();
            sharpened_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) check_result();
            if (i_cfg_valid && i_cfg_ready) write_register(i_cfg_index, i_cfg_data);
            if (i_s_tvalid && i_s_tready) take_pixel_request(bgr_t'(i_s_tdata), i_s_tuser);
        end
        o_pending <= sharpened_q.size();
        o_errors <= mismatches;
    end

endmodule

[tb/laplacian_sharpen_3x3_unit_tb.sv]
`timescale 1ns / 100ps
// laplacian_sharpen_3x3_unit_tb: drives frames of bgr pixels, drain requests and register
// writes into the sharpening unit; laplacian_sharpen_3x3_checker predicts and compares
// depends on lss_pkg, laplacian_sharpen_3x3_unit and laplacian_sharpen_3x3_checker

module laplacian_sharpen_3x3_unit_tb;
    import lss_pkg::*;

    localparam int CFG_D_BITS     = (3*DEF_COEF_BITS > CFG_H_BITS) ? 3*DEF_COEF_BITS : CFG_H_BITS;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_STALL     = 300;
    localparam int SETTLE_CYCLES  = 12;
    localparam int RANDOM_ITEMS   = 2000;

    typedef enum int {PIX_NOISE, PIX_SMOOTH, PIX_EXTREME} pix_style_e;
    typedef enum int {KERN_EDGE, KERN_SMALL, KERN_WILD} kern_style_e;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_D_BITS-1:0]   i_cfg_data = '0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [23:0]             i_s_axis_tdata = '0;   // in_blue, in_green, in_red
    logic                    i_s_axis_tuser = 1'b0; // drain
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    logic [23:0]             o_m_axis_tdata;        // out_blue, out_green, out_red
    logic                    o_m_axis_tlast;        // frame_end

    int check_errors;
    int results_waiting;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int items_sent = 0;
    int quiet_cycles = 0;
    logic stall_now = 1'b0;

    laplacian_sharpen_3x3_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    laplacian_sharpen_3x3_checker u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_axis_tvalid),
        .i_s_tready  (o_s_axis_tready),
        .i_s_tdata   (i_s_axis_tdata),
        .i_s_tuser   (i_s_axis_tuser),
        .i_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .i_m_tdata   (o_m_axis_tdata),
        .i_m_tlast   (o_m_axis_tlast),
        .o_errors    (check_errors),
        .o_pending   (results_waiting)
    );

    always #1 i_clk = ~i_clk;

    // receiver: random back-pressure, or one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_now) begin
                stall_now = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_cfg_valid && o_cfg_ready) || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_D_BITS-1:0] value);
        i_cfg_index <= idx;
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_item(logic [23:0] data, logic drain);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tdata <= data;
        i_s_axis_tuser <= drain;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
    endtask

    task automatic wait_results_done();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (results_waiting != 0) @(posedge i_clk);
    endtask

    // idle point for register writes: nothing expected and the pipeline run dry
    task automatic settle();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [23:0] pixel_value(pix_style_e style, int base);
        logic [23:0] px;
        int          k, v;
        px = $urandom;
        for (k = 0; k < 3; k++) begin
            if (style == PIX_EXTREME) begin
                px[k*8 +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
            end else if (style == PIX_SMOOTH) begin
                v = base + int'($urandom_range(16)) - 8;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                px[k*8 +: 8] = 8'(v);
            end
        end
        return px;
    endfunction

    task automatic load_kernel(kern_style_e style);
        logic signed [7:0] k [3][3];
        int                col, row, s;
        bit                eight;
        s = $urandom_range(1) ? 1 : -1;
        eight = $urandom_range(1);
        for (col = 0; col < 3; col++) begin
            for (row = 0; row < 3; row++) begin
                case (style)
                    KERN_EDGE: begin
                        if (col == 1 && row == 1)
                            k[col][row] = eight ? 8 * s : 4 * s;
                        else if (eight || col == 1 || row == 1)
                            k[col][row] = -s;
                        else
                            k[col][row] = 0;
                    end
                    KERN_SMALL: k[col][row] = int'($urandom_range(6)) - 3;
                    default:    k[col][row] = $urandom;
                endcase
            end
        end
        write_reg(REG_KERNEL_LEFT,   {k[0][2], k[0][1], k[0][0]});
        write_reg(REG_KERNEL_CENTRE, {k[1][2], k[1][1], k[1][0]});
        write_reg(REG_KERNEL_RIGHT,  {k[2][2], k[2][1], k[2][0]});
    endtask

    task automatic set_frame_size(logic [CFG_W_BITS-1:0] w, logic [CFG_H_BITS-1:0] h);
        write_reg(REG_IMAGE_WIDTH, {12'($urandom), w});
        write_reg(REG_IMAGE_HEIGHT, {11'($urandom), h});
    endtask

    // one frame of pixel requests, then, unless cut short, the drain requests that flush its tail
    task automatic stream_frame(int unsigned w, int unsigned h, pix_style_e style,
                                bit may_abort, bit pause_mid, output bit aborted);
        int unsigned total, stop_at, flush, n;
        int          base;
        total = w * h;
        stop_at = total;
        if (may_abort && $urandom_range(9) == 0) stop_at = $urandom_range(total);
        base = $urandom_range(255);
        for (n = 0; n < stop_at; n++) begin
            if (pause_mid && n == stop_at / 2) wait_results_done();
            // drain before the frame is in: no effect
            if ($urandom_range(19) == 0) send_item($urandom, 1'b1);
            send_item(pixel_value(style, base), 1'b0);
            items_sent++;
        end
        aborted = (stop_at < total);
        if (aborted) return;
        flush = (total < w + 1) ? total : w + 1;
        for (n = 0; n < flush; n++) begin
            // a pixel while the tail is pending is dropped and flushes like a drain
            if ($urandom_range(9) == 0)
                send_item(pixel_value(style, base), 1'b0);
            else
                send_item($urandom, 1'b1);
            items_sent++;
        end
        if ($urandom_range(7) == 0) send_item($urandom, 1'b1);
    endtask

    task automatic random_frames(int target, bit with_pause);
        bit          need_size, aborted, pause_left;
        int unsigned w, h;
        need_size = 1'b1;
        pause_left = with_pause;
        while (items_sent < target) begin
            if (need_size || $urandom_range(2) == 0) begin
                settle();
                w = ($urandom_range(3) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 40);
                h = ($urandom_range(3) != 0) ? $urandom_range(1, 6) : $urandom_range(7, 12);
                set_frame_size(w, h);
                if (need_size || $urandom_range(9) < 6)
                    load_kernel(kern_style_e'($urandom_range(2)));
                if ($urandom_range(7) == 0)
                    write_reg(CFG_IDX_BITS'($urandom_range(5, 7)), $urandom);
            end
            stream_frame(w, h, pix_style_e'($urandom_range(2)), 1'b1,
                         pause_left && w * h >= 4, aborted);
            if (w * h >= 4) pause_left = 1'b0;
            need_size = aborted;
        end
    endtask

    initial begin
        int  n;
        bit  aborted;
        tx_idle_pct = 38;
        rx_idle_pct = 59;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero sizes saturate to a 1x1 frame; extreme kernel weights
        write_reg(REG_IMAGE_WIDTH, 24'hFFF000);
        write_reg(REG_IMAGE_HEIGHT, 24'hFFE000);
        write_reg(REG_KERNEL_LEFT, 24'h808080);
        write_reg(REG_KERNEL_CENTRE, 24'h7F7F7F);
        write_reg(REG_KERNEL_RIGHT, 24'h807F80);
        send_item(24'hFFFFFF, 1'b1);
        send_item(24'h000000, 1'b0);
        send_item(24'hFFFFFF, 1'b0);
        send_item(24'h123456, 1'b1);
        settle();

        // 3x3 frame with a single interior pixel
        set_frame_size(3, 3);
        for (n = 0; n < 9; n++) begin
            send_item((n == 4) ? 24'h3F80C1 : ((n % 2) ? 24'hFFFFFF : 24'h000000), 1'b0);
            if (n == 4) send_item(24'hFFFFFF, 1'b1);
        end
        for (n = 0; n < 4; n++) send_item(24'h000000, 1'b1);
        // partial frame, thrown away by the next size write
        for (n = 0; n < 4; n++) send_item($urandom, 1'b0);

        random_frames(RANDOM_ITEMS / 3, 1'b1);

        tx_idle_pct = 59;
        rx_idle_pct = 38;
        random_frames(2 * RANDOM_ITEMS / 3, 1'b0);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        // long output hold-off while requests keep coming
        settle();
        set_frame_size(20, 8);
        load_kernel(KERN_EDGE);
        stall_now = 1'b1;
        stream_frame(20, 8, PIX_SMOOTH, 1'b0, 1'b0, aborted);
        random_frames(RANDOM_ITEMS, 1'b0);

        // widest frame, width register beyond range
        settle();
        write_reg(REG_IMAGE_WIDTH, 24'hABCFFF);
        write_reg(REG_IMAGE_HEIGHT, 24'h000003);
        load_kernel(KERN_SMALL);
        stream_frame(DEF_MAX_WIDTH, 3, PIX_SMOOTH, 1'b0, 1'b0, aborted);

        // tallest frame, height register beyond range
        settle();
        write_reg(REG_IMAGE_WIDTH, 24'h000001);
        write_reg(REG_IMAGE_HEIGHT, 24'h001FFF);
        stream_frame(1, DEF_MAX_HEIGHT, PIX_NOISE, 1'b0, 1'b0, aborted);

        settle();
        if (check_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
sv/lss_pkg.sv
sv/lss_cell.sv
sv/laplacian_sharpen_3x3_unit.sv
tb/laplacian_sharpen_3x3_checker.sv
tb/laplacian_sharpen_3x3_unit_tb.sv
